// ===== sv/aic_pkg.sv =====
package aic_pkg;

	// Field widths
	localparam int DATA_W = 32;
	localparam int BATT_W = 7;
	localparam int LVL_W  = 4;
	localparam int LED_W  = 3;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 3;
	localparam int BLINK_W = 8;

	// Level and blink settings
	localparam int LEVEL_COUNT  = 10;
	localparam int BLINK_PERIOD = 20;
	localparam int MOD_W        = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
	localparam logic [LVL_W-1:0] LEVEL_TOP = LVL_W'(LEVEL_COUNT - 1);

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOSE_THR = 1'b1;
	localparam logic [DATA_W-1:0] THR_RESET = 32'd1000;

	// Battery level above which the pack counts as full
	localparam logic [BATT_W-1:0] BATT_FULL_PCT = 7'd99;

	// Charge status codes
	localparam logic [STAT_W-1:0] CHG_UNPLUGGED = 2'd0;
	localparam logic [STAT_W-1:0] CHG_CHARGING  = 2'd1;
	localparam logic [STAT_W-1:0] CHG_FULL      = 2'd2;

	// LED codes
	localparam logic [LED_W-1:0] LED_NONE   = 3'b000;
	localparam logic [LED_W-1:0] LED_IDLE   = 3'b001;
	localparam logic [LED_W-1:0] LED_CHARGE = 3'b010;
	localparam logic [LED_W-1:0] LED_ALARM  = 3'b100;

	// Beep on/off lengths per level; levels past nine reuse level nine
	localparam logic [CNT_W-1:0] ON_TABLE [16] = '{
		3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3,
		3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
	};
	localparam logic [CNT_W-1:0] OFF_TABLE [16] = '{
		3'd1, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1,
		3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
	};

	// Queue between classifier and sequencer
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Classified tick handed to the back end
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             plug;
		logic             batt_full;
		logic             busy;
	} aic_item_t;

	// Result word
	typedef struct packed {
		logic [LVL_W-1:0]  warn_level;
		logic              beep_on;
		logic [LED_W-1:0]  led_bits;
		logic              charge_enable;
		logic [STAT_W-1:0] charge_status;
	} aic_result_t;

	// Queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} aic_qstat_t;

endpackage

// ===== sv/aic_in_if.sv =====
interface aic_in_if;
	import aic_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] dose_rate;
	logic [DATA_W-1:0] total_dose;
	logic              plug_present;
	logic [BATT_W-1:0] battery_percent;
	logic              charger_busy;

	modport source (output valid, dose_rate, total_dose, plug_present, battery_percent,
		charger_busy, input ready);
	modport sink (input valid, dose_rate, total_dose, plug_present, battery_percent,
		charger_busy, output ready);
endinterface

// ===== sv/aic_out_if.sv =====
interface aic_out_if;
	import aic_pkg::*;

	logic              valid;
	logic              ready;
	logic [LVL_W-1:0]  warn_level;
	logic              beep_on;
	logic [LED_W-1:0]  led_bits;
	logic              charge_enable;
	logic [STAT_W-1:0] charge_status;

	modport source (output valid, warn_level, beep_on, led_bits, charge_enable,
		charge_status, input ready);
	modport sink (input valid, warn_level, beep_on, led_bits, charge_enable,
		charge_status, output ready);
endinterface

// ===== sv/aic_cfg_if.sv =====
interface aic_cfg_if;
	import aic_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [DATA_W-1:0]    data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== sv/aic_front.sv =====
module aic_front (
	input  logic               clk,
	input  logic               arst_n,
	aic_in_if.sink             in_ch,
	aic_cfg_if.sink            cfg,
	input  aic_pkg::aic_qstat_t qstat,
	output logic               push,
	output aic_pkg::aic_item_t push_item
);
	import aic_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t      state_q;
	logic [DATA_W-1:0] rate_thr_q;
	logic [DATA_W-1:0] dose_thr_q;
	logic [DATA_W-1:0] rate_rem_q;
	logic [DATA_W-1:0] dose_rem_q;
	logic [LVL_W-1:0]  rate_lvl_q;
	logic [LVL_W-1:0]  dose_lvl_q;
	logic [LVL_W-1:0]  step_q;
	logic              plug_q;
	logic              batt_full_q;
	logic              busy_q;
	logic              accept;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (state_q == F_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Hold the level thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_thr_q <= THR_RESET;
			dose_thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			if (cfg.addr == CFG_RATE_THR)
				rate_thr_q <= cfg.data;
			if (cfg.addr == CFG_DOSE_THR)
				dose_thr_q <= cfg.data;
		end
	end

	// Sequence accept, saturating divide, hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					step_q <= '0;
					if (accept)
						state_q <= F_DIV;
				end
				F_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LEVEL_TOP - 1'b1)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!qstat.full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Subtract one threshold per cycle; a fixed count of steps caps the level
	always_ff @(posedge clk) begin
		if (accept) begin
			rate_rem_q  <= in_ch.dose_rate;
			dose_rem_q  <= in_ch.total_dose;
			rate_lvl_q  <= '0;
			dose_lvl_q  <= '0;
			plug_q      <= in_ch.plug_present;
			batt_full_q <= (in_ch.battery_percent > BATT_FULL_PCT);
			busy_q      <= in_ch.charger_busy;
		end else if (state_q == F_DIV) begin
			if (rate_rem_q >= rate_thr_q) begin
				rate_rem_q <= rate_rem_q - rate_thr_q;
				rate_lvl_q <= rate_lvl_q + 1'b1;
			end
			if (dose_rem_q >= dose_thr_q) begin
				dose_rem_q <= dose_rem_q - dose_thr_q;
				dose_lvl_q <= dose_lvl_q + 1'b1;
			end
		end
	end

	// Pick the larger level and push the classified word
	always_comb begin
		push                = (state_q == F_PUSH) && !qstat.full;
		push_item.level     = (rate_lvl_q > dose_lvl_q) ? rate_lvl_q : dose_lvl_q;
		push_item.plug      = plug_q;
		push_item.batt_full = batt_full_q;
		push_item.busy      = busy_q;
	end

endmodule

// ===== sv/aic_queue.sv =====
module aic_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  aic_pkg::aic_item_t  push_item,
	input  logic                pop,
	output aic_pkg::aic_item_t  head,
	output aic_pkg::aic_qstat_t qstat
);
	import aic_pkg::*;

	aic_item_t         mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== sv/aic_back.sv =====
module aic_back (
	input  logic                clk,
	input  logic                arst_n,
	input  aic_pkg::aic_item_t  head,
	input  aic_pkg::aic_qstat_t qstat,
	output logic                pop,
	aic_out_if.source           out_ch
);
	import aic_pkg::*;

	typedef enum logic [2:0] {
		PH_RELOAD = 3'b001,
		PH_ON     = 3'b010,
		PH_OFF    = 3'b100
	} beep_phase_t;

	beep_phase_t       phase_q;
	logic [LVL_W-1:0]  last_level_q;
	logic [CNT_W-1:0]  on_left_q;
	logic [CNT_W-1:0]  off_left_q;
	logic [BLINK_W-1:0] blink_q;
	logic [MOD_W-1:0]  blink_mod_q;
	logic [STAT_W-1:0] mode_q;
	logic              out_valid_q;
	aic_result_t       res_q;

	beep_phase_t       phase_n;
	logic [CNT_W-1:0]  on_n;
	logic [CNT_W-1:0]  off_n;
	logic [BLINK_W-1:0] blink_n;
	logic [MOD_W-1:0]  blink_mod_n;
	logic              on_half;
	logic              beep;
	logic [LED_W-1:0]  leds;
	logic              enable;
	logic [STAT_W-1:0] mode_n;

	assign pop = !qstat.empty && (!out_valid_q || out_ch.ready);

	// Beep sequencer step
	always_comb begin
		phase_n = (head.level != last_level_q) ? PH_RELOAD : phase_q;
		on_n    = on_left_q;
		off_n   = off_left_q;
		beep    = 1'b0;
		if (phase_n == PH_RELOAD) begin
			on_n    = ON_TABLE[head.level];
			off_n   = OFF_TABLE[head.level];
			phase_n = PH_ON;
		end
		case (phase_n)
			PH_ON: begin
				if (on_n != '0) begin
					beep = 1'b1;
					on_n = on_n - 1'b1;
				end else begin
					phase_n = PH_OFF;
				end
			end
			PH_OFF: begin
				if (off_n != '0)
					off_n = off_n - 1'b1;
				else
					phase_n = PH_RELOAD;
			end
			default: beep = 1'b0;
		endcase
	end

	// Blink counter and its position in the blink period
	always_comb begin
		blink_n = blink_q + 1'b1;
		if (blink_n == '0)
			blink_mod_n = '0;
		else if (blink_mod_q == MOD_W'(BLINK_PERIOD - 1))
			blink_mod_n = '0;
		else
			blink_mod_n = blink_mod_q + 1'b1;
		on_half = (blink_mod_n < MOD_W'(BLINK_PERIOD / 2));
	end

	// LEDs from the charge state of the previous tick
	always_comb begin
		if (head.level != '0)
			leds = LED_ALARM;
		else if (mode_q == CHG_FULL)
			leds = LED_CHARGE;
		else if (mode_q == CHG_CHARGING)
			leds = on_half ? LED_CHARGE : LED_NONE;
		else
			leds = on_half ? LED_IDLE : LED_NONE;
	end

	// Charge state machine
	always_comb begin
		enable = 1'b0;
		if (!head.plug) begin
			mode_n = CHG_UNPLUGGED;
		end else if (head.batt_full) begin
			mode_n = CHG_FULL;
		end else if (head.busy) begin
			enable = 1'b1;
			mode_n = CHG_CHARGING;
		end else begin
			mode_n = CHG_FULL;
		end
	end

	// Commit state on each popped tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_ON;
			last_level_q <= '0;
			on_left_q    <= '0;
			off_left_q   <= CNT_W'(1);
			blink_q      <= '0;
			blink_mod_q  <= '0;
			mode_q       <= CHG_UNPLUGGED;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_n;
				last_level_q <= head.level;
				on_left_q    <= on_n;
				off_left_q   <= off_n;
				blink_q      <= blink_n;
				blink_mod_q  <= blink_mod_n;
				mode_q       <= mode_n;
				out_valid_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.warn_level    <= head.level;
			res_q.beep_on       <= beep;
			res_q.led_bits      <= leds;
			res_q.charge_enable <= enable;
			res_q.charge_status <= mode_n;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.warn_level    = res_q.warn_level;
	assign out_ch.beep_on       = res_q.beep_on;
	assign out_ch.led_bits      = res_q.led_bits;
	assign out_ch.charge_enable = res_q.charge_enable;
	assign out_ch.charge_status = res_q.charge_status;

endmodule

// ===== sv/alarm_indicator_controller.sv =====
// Alarm indicator controller: turns one status tick into buzzer, LED and
// charger drive.
// in_ch: one word per tick with dose rate, total dose and charger inputs.
// cfg: register writes, addr 0 is the rate threshold, addr 1 the dose
// threshold; always ready, to be written only while no tick is in flight.
// out_ch: one result word per tick, in tick order.
// The front end takes a tick, then runs the saturating divide of both
// readings by their thresholds, one subtract per cycle over nine steps,
// then pushes the word into the queue; in_ch is ready only while the
// front end is idle, so no new tick is taken until that push. A
// two-entry queue feeds the sequencer, which forms the result
// combinationally into an output register.
// When out_ch stalls, the result register holds, the queue fills, and
// then the front end waits to push, keeping in_ch not ready.
// Reset sets both thresholds to 1000, clears the queue, the blink counter
// and the charge state, and starts the beep sequencer in its on phase.
module alarm_indicator_controller (
	input  logic      clk,
	input  logic      arst_n,
	aic_in_if.sink    in_ch,
	aic_cfg_if.sink   cfg,
	aic_out_if.source out_ch
);
	import aic_pkg::*;

	aic_item_t  push_item;
	aic_item_t  head;
	aic_qstat_t qstat;
	logic       push;
	logic       pop;

	aic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	aic_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	aic_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aic_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_AFTER    = 400;
	localparam int HOLD_CYCLES   = 150;
	localparam int REPORT_CAP    = 40;
	localparam int N_DIRECTED    = 25;
	localparam int N_PHASES      = 6;
	localparam int RANDOM_PHASE  = 4;

	// One status tick as it goes onto in_ch
	typedef struct packed {
		logic [DATA_W-1:0] rate;
		logic [DATA_W-1:0] dose;
		logic              plug;
		logic [BATT_W-1:0] batt;
		logic              busy;
	} tick_t;

	// Directed step: tick plus, where it is obvious, the word it must give
	typedef struct packed {
		tick_t       t;
		logic        typed;
		aic_result_t want;
	} step_row_t;

	typedef enum logic [1:0] {
		PH_RELOAD = 2'd0,
		PH_ON     = 2'd1,
		PH_OFF    = 2'd2
	} beep_phase_t;

	localparam aic_result_t UNTYPED = '0;

	// Beep on/off lengths per warn level
	localparam logic [CNT_W-1:0] ON_LEN [16] = '{
		3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3,
		3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
	};
	localparam logic [CNT_W-1:0] OFF_LEN [16] = '{
		3'd1, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1,
		3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
	};

	// Threshold settings and tick counts of the random phases
	localparam logic [DATA_W-1:0] PHASE_RATE [N_PHASES] = '{
		32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd0, 32'd7
	};
	localparam logic [DATA_W-1:0] PHASE_DOSE [N_PHASES] = '{
		32'd1, 32'hFFFF_FFFF, 32'd0, 32'd250000, 32'd0, 32'hFFFF_FFFF
	};
	localparam int PHASE_LEN [N_PHASES] = '{120, 120, 60, 200, 250, 200};

	step_row_t directed_rows [N_DIRECTED] = '{
		'{'{32'd0, 32'd0, 1'b0, 7'd0, 1'b0}, 1'b1,
			'{4'd0, 1'b0, LED_IDLE, 1'b0, CHG_UNPLUGGED}},
		'{'{32'hFFFF_FFFF, 32'd0, 1'b1, 7'd100, 1'b1}, 1'b1,
			'{4'd9, 1'b1, LED_ALARM, 1'b0, CHG_FULL}},
		'{'{32'd0, 32'hFFFF_FFFF, 1'b1, 7'd99, 1'b1}, 1'b1,
			'{4'd9, 1'b0, LED_ALARM, 1'b1, CHG_CHARGING}},
		'{'{32'd0, 32'd0, 1'b1, 7'd50, 1'b0}, 1'b1,
			'{4'd0, 1'b0, LED_CHARGE, 1'b0, CHG_FULL}},
		'{'{32'd0, 32'd0, 1'b0, 7'd0, 1'b1}, 1'b1,
			'{4'd0, 1'b0, LED_CHARGE, 1'b0, CHG_UNPLUGGED}},
		'{'{32'd999, 32'd0, 1'b1, 7'd100, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd1000, 32'd0, 1'b1, 7'd100, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd1000, 32'd999, 1'b1, 7'd100, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd1999, 32'd1000, 1'b1, 7'd100, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd1000, 32'd1000, 1'b1, 7'd0, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd2000, 32'd0, 1'b1, 7'd0, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd0, 32'd3000, 1'b1, 7'd1, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd4000, 32'd0, 1'b0, 7'd64, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd5999, 32'd5000, 1'b0, 7'd63, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd6000, 32'd0, 1'b1, 7'd98, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd6000, 32'd0, 1'b1, 7'd98, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd7000, 32'd0, 1'b1, 7'd42, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd7000, 32'd0, 1'b1, 7'd42, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd8000, 32'd0, 1'b0, 7'd21, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd8000, 32'd0, 1'b0, 7'd21, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd8000, 32'd0, 1'b0, 7'd21, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd9000, 32'd0, 1'b1, 7'd85, 1'b1}, 1'b0, UNTYPED},
		'{'{32'd9999, 32'd10000, 1'b1, 7'd85, 1'b1}, 1'b0, UNTYPED},
		'{'{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 7'd100, 1'b0}, 1'b0, UNTYPED},
		'{'{32'd0, 32'd0, 1'b1, 7'd100, 1'b1}, 1'b0, UNTYPED}
	};

	logic clk;
	logic arst_n;

	aic_in_if  in_ch();
	aic_cfg_if cfg();
	aic_out_if out_ch();

	alarm_indicator_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	// Indicator state as the block should hold it
	logic [DATA_W-1:0]  thr_rate;
	logic [DATA_W-1:0]  thr_dose;
	beep_phase_t        bp_phase;
	logic [LVL_W-1:0]   bp_last;
	logic [CNT_W-1:0]   bp_on;
	logic [CNT_W-1:0]   bp_off;
	logic [BLINK_W-1:0] blink;
	logic [STAT_W-1:0]  chg_mode;

	aic_result_t expected_words[$];
	int unsigned errors;
	int unsigned words_checked;
	int unsigned ticks_in;
	int unsigned cycles;
	bit          pacing_on;
	bit          long_hold_done;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		// keep the log short when something is badly broken
		if (errors <= REPORT_CAP)
			$display("mismatch on word %0d: %s got %0d want %0d", words_checked, what, got, want);
	endtask

	function automatic logic [LVL_W-1:0] level_term(logic [DATA_W-1:0] v, logic [DATA_W-1:0] step);
		logic [DATA_W-1:0] q;
		if (step == 0)
			return LVL_W'(LEVEL_COUNT - 1);
		q = v / step;
		return (q > LEVEL_COUNT - 1) ? LVL_W'(LEVEL_COUNT - 1) : q[LVL_W-1:0];
	endfunction

	// Advance the indicator state by one tick and form its result word
	function automatic aic_result_t advance_indicator(tick_t t);
		logic [LVL_W-1:0] a;
		logic [LVL_W-1:0] b;
		logic             on_half;
		aic_result_t      r;
		a = level_term(t.rate, thr_rate);
		b = level_term(t.dose, thr_dose);
		r = '0;
		r.warn_level = (a > b) ? a : b;

		// beep sequencer, reloaded on a level change
		if (r.warn_level != bp_last) begin
			bp_last = r.warn_level;
			bp_phase = PH_RELOAD;
		end
		if (bp_phase == PH_RELOAD) begin
			bp_on = ON_LEN[r.warn_level];
			bp_off = OFF_LEN[r.warn_level];
			bp_phase = PH_ON;
		end
		if (bp_phase == PH_ON) begin
			if (bp_on != 0) begin
				r.beep_on = 1'b1;
				bp_on = bp_on - 1'b1;
			end else begin
				bp_phase = PH_OFF;
			end
		end else if (bp_phase == PH_OFF) begin
			if (bp_off != 0)
				bp_off = bp_off - 1'b1;
			else
				bp_phase = PH_RELOAD;
		end

		// LEDs from the charge state of the previous tick
		blink = blink + 1'b1;
		on_half = (blink % BLINK_PERIOD) < (BLINK_PERIOD / 2);
		if (r.warn_level != 0)
			r.led_bits = LED_ALARM;
		else if (chg_mode == CHG_FULL)
			r.led_bits = LED_CHARGE;
		else if (chg_mode == CHG_CHARGING)
			r.led_bits = on_half ? LED_CHARGE : LED_NONE;
		else
			r.led_bits = on_half ? LED_IDLE : LED_NONE;

		// charge state machine
		if (!t.plug) begin
			chg_mode = CHG_UNPLUGGED;
		end else if (t.batt > BATT_FULL_PCT) begin
			chg_mode = CHG_FULL;
		end else if (t.busy) begin
			r.charge_enable = 1'b1;
			chg_mode = CHG_CHARGING;
		end else begin
			chg_mode = CHG_FULL;
		end
		r.charge_status = chg_mode;
		return r;
	endfunction

	// Pick a reading near a multiple of the threshold, an extreme, or a random value
	function automatic logic [DATA_W-1:0] near_step(logic [DATA_W-1:0] step);
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = 64'd0;
			1: v = 64'hFFFF_FFFF;
			2, 3: v = 64'($urandom);
			default: begin
				v = 64'(step) * 64'($urandom_range(0, 11));
				case ($urandom_range(0, 2))
					0: ;
					1: if (step != 0) v = v + 64'(step) - 64'd1;
					default: v = v + 64'((step == 0) ? $urandom_range(0, 3) : $urandom_range(0, step - 1));
				endcase
			end
		endcase
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[DATA_W-1:0];
	endfunction

	// Hold readings for a few ticks so the beep pattern runs; sometimes scramble all
	function automatic tick_t vary_tick(tick_t prev, logic [DATA_W-1:0] rs, logic [DATA_W-1:0] ds);
		tick_t t;
		t = prev;
		if ($urandom_range(0, 15) == 0) begin
			t.rate = $urandom;
			t.dose = $urandom;
			t.plug = 1'($urandom);
			t.busy = 1'($urandom);
			t.batt = BATT_W'($urandom_range(0, 100));
		end else begin
			if ($urandom_range(0, 9) == 0)
				t.rate = near_step(rs);
			if ($urandom_range(0, 9) == 0)
				t.dose = near_step(ds);
			if ($urandom_range(0, 7) == 0) begin
				t.plug = 1'($urandom);
				t.busy = 1'($urandom);
				t.batt = ($urandom_range(0, 2) == 0) ? BATT_W'($urandom_range(98, 100))
					: BATT_W'($urandom_range(0, 100));
			end
		end
		return t;
	endfunction

	// Offer one tick, wait for the handshake, then log its expected word
	task automatic send_tick(input tick_t t, input logic typed, input aic_result_t want);
		aic_result_t got;
		if (pacing_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.dose_rate <= t.rate;
		in_ch.total_dose <= t.dose;
		in_ch.plug_present <= t.plug;
		in_ch.battery_percent <= t.batt;
		in_ch.charger_busy <= t.busy;
		do @(posedge clk); while (!in_ch.ready);
		ticks_in++;
		got = advance_indicator(t);
		expected_words.push_back(typed ? want : got);
	endtask

	// Leaves cfg.valid high so back-to-back writes need no re-raise
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == CFG_RATE_THR)
			thr_rate = val;
		else
			thr_dose = val;
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus: reset, directed table, then random phases under new thresholds
	initial begin : stimulus
		tick_t             cur;
		logic [DATA_W-1:0] rs;
		logic [DATA_W-1:0] ds;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.dose_rate = '0;
		in_ch.total_dose = '0;
		in_ch.plug_present = 1'b0;
		in_ch.battery_percent = '0;
		in_ch.charger_busy = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = CFG_RATE_THR;
		cfg.data = '0;
		thr_rate = THR_RESET;
		thr_dose = THR_RESET;
		bp_phase = PH_ON;
		bp_last = '0;
		bp_on = '0;
		bp_off = 3'd1;
		blink = '0;
		chg_mode = CHG_UNPLUGGED;
		pacing_on = 1'b1;
		cur = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			rs = PHASE_RATE[p];
			ds = PHASE_DOSE[p];
			if (p == RANDOM_PHASE) begin
				rs = $urandom_range(1, 100000);
				ds = $urandom_range(1, 100000);
			end
			write_reg(CFG_RATE_THR, rs);
			write_reg(CFG_DOSE_THR, ds);
			cfg.valid <= 1'b0;
			// no idling on either side in the last phase
			pacing_on = (p != N_PHASES - 1);
			for (int n = 0; n < PHASE_LEN[p]; n++) begin
				cur = vary_tick(cur, rs, ds);
				send_tick(cur, 1'b0, UNTYPED);
			end
		end
		settle();

		if (expected_words.size() != 0)
			report_mismatch("words never seen", 0, expected_words.size());
		$display("Ran %0d status ticks and checked %0d result words over %0d threshold settings,",
			ticks_in, words_checked, N_PHASES + 1);
		$display("with random gaps on both sides and one output stall of %0d cycles.",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Output ready: random stall bursts, and one long hold so the block backs up
	initial begin : out_pacing
		out_ch.ready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && ticks_in >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (pacing_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : check_words
		aic_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected", 1, 0);
			end else begin
				want = expected_words.pop_front();
				if (out_ch.warn_level !== want.warn_level)
					report_mismatch("warn_level", out_ch.warn_level, want.warn_level);
				if (out_ch.beep_on !== want.beep_on)
					report_mismatch("beep_on", out_ch.beep_on, want.beep_on);
				if (out_ch.led_bits !== want.led_bits)
					report_mismatch("led_bits", out_ch.led_bits, want.led_bits);
				if (out_ch.charge_enable !== want.charge_enable)
					report_mismatch("charge_enable", out_ch.charge_enable, want.charge_enable);
				if (out_ch.charge_status !== want.charge_status)
					report_mismatch("charge_status", out_ch.charge_status, want.charge_status);
			end
			words_checked++;
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				expected_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
